### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the change dispenser RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define GCHG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define GCHG_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define GCHG_ASSERT(lbl, clk, rst_n, prop, msg)
`define GCHG_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

### sv/gchg_pkg.sv
// ----------------------------------------------------------------------------
// gchg_pkg
// Types and constants shared by the greedy change dispenser modules.
// ----------------------------------------------------------------------------
package gchg_pkg;

    localparam int DATA_W      = 16;
    localparam int SLOTS       = 8;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int MAX_RESULTS = 8;
    localparam int NCNT_W      = $clog2(MAX_RESULTS + 1);
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    // Transaction kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_REQ  = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [2:0]        slot;
        logic [DATA_W-1:0] denom_value;
        logic [DATA_W-1:0] denom_count;
        logic [DATA_W-1:0] amount;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] paid_value;
        logic [DATA_W-1:0] paid_count;
        logic [DATA_W-1:0] remainder;
        logic              shortfall;
        logic              last;
    } rsp_t;

    // Table write port
    typedef struct packed {
        logic              denom_we;
        logic              stock_we;
        logic [SLOT_W-1:0] addr;
        logic [DATA_W-1:0] denom;
        logic [DATA_W-1:0] stock;
    } tbl_wr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_MUL,
        ST_UPD,
        ST_FINISH
    } state_t;

endpackage

### sv/greedy_change_dispenser_core.sv
// ----------------------------------------------------------------------------
// greedy_change_dispenser_core
// Greedy change dispenser over a table of denominations with limited stock.
// ----------------------------------------------------------------------------
// Load transaction: no result; next transaction accepted next cycle.
// Request: each slot used goes through check, divide steps, divider done,
// multiply and update; each skipped slot goes through a check only.
// Next transaction taken once the last result is valid; output stalls delay it.
// Reset (async, active low) clears the sequencer and zeroes both tables.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module greedy_change_dispenser_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  gchg_pkg::req_t   in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output gchg_pkg::rsp_t   out_data
);

    gchg_pkg::state_t                   state_reg, state_next;
    logic [gchg_pkg::CNT_W-1:0]         idx_reg, idx_next;
    logic [gchg_pkg::NCNT_W-1:0]        n_reg, n_next;
    logic [gchg_pkg::DATA_W-1:0]        rem_reg, rem_next;
    logic [gchg_pkg::DATA_W-1:0]        pieces_reg, pieces_next;
    logic [2*gchg_pkg::DATA_W-1:0]      prod_reg, prod_next;
    logic                               held_vld_reg, held_vld_next;
    gchg_pkg::rsp_t                     held_reg, held_next;
    logic                               out_valid_reg, out_valid_next;
    gchg_pkg::rsp_t                     out_reg, out_next;

    gchg_pkg::tbl_wr_t                  tbl_wr;
    logic [gchg_pkg::DATA_W-1:0]        rd_denom;
    logic [gchg_pkg::DATA_W-1:0]        rd_stock;
    logic                               div_start;
    logic                               div_done;
    logic [gchg_pkg::DATA_W-1:0]        div_quo;
    logic                               out_free;
    logic [gchg_pkg::DATA_W-1:0]        upd_rem;

    gchg_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (tbl_wr),
        .rd_idx   (idx_reg[gchg_pkg::SLOT_W-1:0]),
        .rd_denom (rd_denom),
        .rd_stock (rd_stock)
    );

    gchg_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rem_reg),
        .divisor  (rd_denom),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign upd_rem  = rem_reg - prod_reg[gchg_pkg::DATA_W-1:0];

    // Sequencer: next state and datapath controls
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        rem_next       = rem_reg;
        pieces_next    = pieces_reg;
        prod_next      = prod_reg;
        held_vld_next  = held_vld_reg;
        held_next      = held_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        tbl_wr         = '0;
        tbl_wr.addr    = idx_reg[gchg_pkg::SLOT_W-1:0];
        div_start      = 1'b0;
        in_ready       = 1'b0;

        unique case (state_reg)
            gchg_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_data.kind == gchg_pkg::KIND_LOAD)
                    begin
                        if (32'(in_data.slot) < gchg_pkg::SLOTS)
                        begin
                            tbl_wr.denom_we = 1'b1;
                            tbl_wr.stock_we = 1'b1;
                            tbl_wr.addr     = gchg_pkg::SLOT_W'(in_data.slot);
                            tbl_wr.denom    = in_data.denom_value;
                            tbl_wr.stock    = in_data.denom_count;
                        end
                    end
                    else
                    begin
                        rem_next      = in_data.amount;
                        idx_next      = '0;
                        n_next        = '0;
                        held_vld_next = 1'b0;
                        state_next    = gchg_pkg::ST_CHECK;
                    end
                end
            end

            gchg_pkg::ST_CHECK:
            begin
                if (idx_reg == gchg_pkg::CNT_W'(gchg_pkg::SLOTS) || rem_reg == '0 ||
                    n_reg == gchg_pkg::NCNT_W'(gchg_pkg::MAX_RESULTS))
                    state_next = gchg_pkg::ST_FINISH;
                else if (rd_stock == '0 || rd_denom == '0 || rd_denom > rem_reg)
                    idx_next = idx_reg + 1'b1;
                else
                begin
                    div_start  = 1'b1;
                    state_next = gchg_pkg::ST_DIV;
                end
            end

            gchg_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    pieces_next = (div_quo > rd_stock) ? rd_stock : div_quo;
                    state_next  = gchg_pkg::ST_MUL;
                end
            end

            gchg_pkg::ST_MUL:
            begin
                prod_next  = pieces_reg * rd_denom;
                state_next = gchg_pkg::ST_UPD;
            end

            gchg_pkg::ST_UPD:
            begin
                // Previous result goes out once it is known not to be the last
                if (!held_vld_reg || out_free)
                begin
                    if (held_vld_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = held_reg;
                    end
                    held_vld_next        = 1'b1;
                    held_next.paid_value = rd_denom;
                    held_next.paid_count = pieces_reg;
                    held_next.remainder  = upd_rem;
                    held_next.shortfall  = 1'b0;
                    held_next.last       = 1'b0;
                    tbl_wr.stock_we      = 1'b1;
                    tbl_wr.stock         = rd_stock - pieces_reg;
                    rem_next             = upd_rem;
                    n_next               = n_reg + 1'b1;
                    idx_next             = idx_reg + 1'b1;
                    state_next           = gchg_pkg::ST_CHECK;
                end
            end

            gchg_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (held_vld_reg)
                        out_next = held_reg;
                    else
                    begin
                        out_next.paid_value = '0;
                        out_next.paid_count = '0;
                        out_next.remainder  = rem_reg;
                    end
                    out_next.shortfall = (rem_reg != '0);
                    out_next.last      = 1'b1;
                    held_vld_next      = 1'b0;
                    state_next         = gchg_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = gchg_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gchg_pkg::ST_IDLE;
            idx_reg       <= '0;
            n_reg         <= '0;
            held_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            held_vld_reg  <= held_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        pieces_reg <= pieces_next;
        prod_reg   <= prod_next;
        held_reg   <= held_next;
        out_reg    <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `GCHG_ASSERT(a_idle_empty, clk, rst_n, (state_reg == gchg_pkg::ST_IDLE) |-> !held_vld_reg,
                 "held result left over in idle")
    `GCHG_ASSERT(a_n_bound, clk, rst_n,
                 n_reg <= gchg_pkg::NCNT_W'(gchg_pkg::MAX_RESULTS), "result count overflow")
    `GCHG_ASSERT(a_short_last, clk, rst_n, out_valid_reg |-> (!out_reg.shortfall || out_reg.last),
                 "shortfall on a non-final result")
    `GCHG_ASSERT(a_upd_no_underflow, clk, rst_n,
                 (state_reg == gchg_pkg::ST_UPD) |->
                     (prod_reg <= {{gchg_pkg::DATA_W{1'b0}}, rem_reg}),
                 "payout exceeds unpaid amount")

endmodule

### sv/gchg_divider.sv
// ----------------------------------------------------------------------------
// gchg_divider
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gchg_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [gchg_pkg::DATA_W-1:0]   dividend,
    input  logic [gchg_pkg::DATA_W-1:0]   divisor,
    output logic                          done,
    output logic [gchg_pkg::DATA_W-1:0]   quotient
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [gchg_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [gchg_pkg::DATA_W-1:0]     quo_reg;
    logic [gchg_pkg::DATA_W-1:0]     rem_reg;
    logic [gchg_pkg::DATA_W-1:0]     dvs_reg;

    logic [gchg_pkg::DATA_W:0]       shifted;
    logic [gchg_pkg::DATA_W:0]       diff;
    logic                            ge;
    logic [gchg_pkg::DATA_W-1:0]     quo_next;
    logic [gchg_pkg::DATA_W-1:0]     rem_next;

    // One shift-subtract step
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[gchg_pkg::DATA_W-1]};
        diff     = shifted - {1'b0, dvs_reg};
        ge       = (shifted >= {1'b0, dvs_reg});
        rem_next = ge ? diff[gchg_pkg::DATA_W-1:0] : shifted[gchg_pkg::DATA_W-1:0];
        quo_next = {quo_reg[gchg_pkg::DATA_W-2:0], ge};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == gchg_pkg::DIV_CNT_W'(gchg_pkg::DATA_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    `GCHG_NEVER(a_start_busy, clk, rst_n, start && busy_reg, "divider started while busy")
    `GCHG_NEVER(a_zero_div, clk, rst_n, start && (divisor == '0), "divide by zero")
    `GCHG_ASSERT(a_done_pulse, clk, rst_n, done_reg |-> (!busy_reg && $past(busy_reg)),
                 "done without a running division")

endmodule

### sv/gchg_table.sv
// ----------------------------------------------------------------------------
// gchg_table
// Denomination and stock registers, one read port and one write port.
// ----------------------------------------------------------------------------
module gchg_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gchg_pkg::tbl_wr_t             wr,
    input  logic [gchg_pkg::SLOT_W-1:0]   rd_idx,
    output logic [gchg_pkg::DATA_W-1:0]   rd_denom,
    output logic [gchg_pkg::DATA_W-1:0]   rd_stock
);

    logic [gchg_pkg::DATA_W-1:0] denom_reg [gchg_pkg::SLOTS];
    logic [gchg_pkg::DATA_W-1:0] stock_reg [gchg_pkg::SLOTS];

    // Write port, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < gchg_pkg::SLOTS; i++)
            begin
                denom_reg[i] <= '0;
                stock_reg[i] <= '0;
            end
        end
        else
        begin
            if (wr.denom_we)
                denom_reg[wr.addr] <= wr.denom;
            if (wr.stock_we)
                stock_reg[wr.addr] <= wr.stock;
        end
    end

    assign rd_denom = denom_reg[rd_idx];
    assign rd_stock = stock_reg[rd_idx];

endmodule
